FILE: design/ipfl_pkg.sv
// ----------------------------------------------------------------------------
// ipfl_pkg
// Shared widths, opcodes and status codes of the id pool free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfl_pkg;

  // field widths
  localparam int unsigned IdW     = 12;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  // number of distinct 12-bit ids, and the width of a counter that can hold it
  localparam int unsigned IdSpace = 1 << IdW;
  localparam int unsigned CountW  = IdW + 1;

  // default pool capacity
  localparam int unsigned DefaultCapacity = 4096;

  // request opcodes
  localparam logic [OpW-1:0] OpAlloc  = 2'd0;
  localparam logic [OpW-1:0] OpFree   = 2'd1;
  localparam logic [OpW-1:0] OpLookup = 2'd2;
  localparam logic [OpW-1:0] OpBad    = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StBadOp = 2'd2;

endpackage

`default_nettype wire

FILE: design/id_pool_free_list_allocator.sv
// ----------------------------------------------------------------------------
// id_pool_free_list_allocator
// Hands out 12-bit entry ids from a LIFO free list or a bump counter and keeps
// a 16-bit size word per id.
//
// Usage: a request enters on the input channel (in_valid_i / in_ready_o) with
// opcode_i, entry_id_i and scope_size_i; exactly one result leaves on the
// output channel (out_valid_o / out_ready_i) with result_id_o, result_size_o
// and status_o. Allocate pops the free-list head, else takes the next fresh id
// from the bump counter, else reports no id left. Free pushes entry_id_i onto
// the free list. Lookup returns the stored size of entry_id_i.
// In the accept cycle a request reads the link and size memories (synchronous
// read into registers); in the execute state it modifies and writes back and
// loads the output register. One request is in flight at a time, so a new
// request is not taken until the last one has left its execute state.
// The execute state ends and loads the result once the output register is
// free. A new request may be taken while a result waits in the output
// register; if the receiver stalls, the second request waits in its execute
// cycle until the output register frees, and no further request is taken.
// Reset clears the free list, the bump counter and the output valid; the
// memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module id_pool_free_list_allocator
  import ipfl_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OpW-1:0]     opcode_i,
  input  wire logic [IdW-1:0]     entry_id_i,
  input  wire logic [SizeW-1:0]   scope_size_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [IdW-1:0]          result_id_o,
  output logic [SizeW-1:0]        result_size_o,
  output logic [StatusW-1:0]      status_o
);

  // ids beyond the 12-bit range cannot be handed out
  localparam int unsigned UsableCap = (CAPACITY > IdSpace) ? IdSpace : CAPACITY;
  localparam logic [CountW-1:0] UsableCapC = CountW'(UsableCap);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic [IdW-1:0]       res_id_q;
  logic [SizeW-1:0]     res_size_q;
  logic [StatusW-1:0]   res_status_q;
  logic [IdW-1:0]       free_head_q;
  logic                 nonempty_q;
  logic [CountW-1:0]    bump_q;
  logic [OpW-1:0]       op_q;
  logic [IdW-1:0]       op_id_q;
  logic [SizeW-1:0]     op_size_q;

  // memories and their registered read data
  logic [IdW-1:0]       link_mem [IdSpace];
  logic [SizeW-1:0]     size_mem [IdSpace];
  logic [IdW-1:0]       link_rd_q;
  logic [SizeW-1:0]     size_rd_q;

  logic                 in_fire;
  logic                 finish;
  logic                 link_we;
  logic [IdW-1:0]       link_wdata;
  logic                 size_we;
  logic [IdW-1:0]       alloc_id;
  logic [IdW-1:0]       free_head_d;
  logic                 nonempty_d;
  logic [CountW-1:0]    bump_d;
  logic [IdW-1:0]       res_id_d;
  logic [SizeW-1:0]     res_size_d;
  logic [StatusW-1:0]   res_status_d;

  assign in_ready_o    = (state_q == StIdle);
  assign in_fire       = in_valid_i && in_ready_o;
  assign finish        = (state_q == StExec) && (!out_valid_q || out_ready_i);

  assign out_valid_o   = out_valid_q;
  assign result_id_o   = res_id_q;
  assign result_size_o = res_size_q;
  assign status_o      = res_status_q;

  // modify step: decide writes, new list state and the result
  always_comb begin
    link_we      = 1'b0;
    link_wdata   = op_id_q;
    size_we      = 1'b0;
    alloc_id     = free_head_q;
    free_head_d  = free_head_q;
    nonempty_d   = nonempty_q;
    bump_d       = bump_q;
    res_id_d     = op_id_q;
    res_size_d   = '0;
    res_status_d = StOk;
    case (op_q)
      OpAlloc: begin
        if (nonempty_q) begin
          // pop the head; a self-link marks the end of the list
          alloc_id = free_head_q;
          size_we  = 1'b1;
          if (link_rd_q == free_head_q) begin
            nonempty_d = 1'b0;
          end else begin
            free_head_d = link_rd_q;
          end
          res_id_d   = free_head_q;
          res_size_d = op_size_q;
        end else if (bump_q < UsableCapC) begin
          // fresh id from the bump counter
          alloc_id   = bump_q[IdW-1:0];
          size_we    = 1'b1;
          bump_d     = bump_q + CountW'(1);
          res_id_d   = bump_q[IdW-1:0];
          res_size_d = op_size_q;
        end else begin
          res_id_d     = '0;
          res_status_d = StEmpty;
        end
      end
      OpFree: begin
        // push; an empty list ends in a self-link
        link_we     = 1'b1;
        link_wdata  = nonempty_q ? free_head_q : op_id_q;
        free_head_d = op_id_q;
        nonempty_d  = 1'b1;
      end
      OpLookup: begin
        res_size_d = size_rd_q;
      end
      default: begin
        res_status_d = StBadOp;
      end
    endcase
  end

  // sequencer, list state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      res_id_q     <= '0;
      res_size_q   <= '0;
      res_status_q <= StOk;
      free_head_q  <= '0;
      nonempty_q   <= 1'b0;
      bump_q       <= '0;
      op_q         <= OpAlloc;
      op_id_q      <= '0;
      op_size_q    <= '0;
    end else begin
      // output valid: set by a finishing request, cleared when taken
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            op_q      <= opcode_i;
            op_id_q   <= entry_id_i;
            op_size_q <= scope_size_i;
            state_q   <= StExec;
          end
        end
        StExec: begin
          if (finish) begin
            free_head_q  <= free_head_d;
            nonempty_q   <= nonempty_d;
            bump_q       <= bump_d;
            res_id_q     <= res_id_d;
            res_size_q   <= res_size_d;
            res_status_q <= res_status_d;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // memory reads at accept, write-back at finish; the sequencer keeps them apart
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      link_rd_q <= link_mem[free_head_q];
      size_rd_q <= size_mem[entry_id_i];
    end
    if (finish && link_we) begin
      link_mem[op_id_q] <= link_wdata;
    end
    if (finish && size_we) begin
      size_mem[alloc_id] <= op_size_q;
    end
  end

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  // bump counter never passes the usable capacity
  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= UsableCapC)
    else $error("bump counter beyond capacity");

  // an exhausted pool result carries a zero id and a zero size
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StEmpty) |-> (result_id_o == '0 && result_size_o == '0))
    else $error("exhausted result carries an id or size");

  // a result follows its request directly when the output is free
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (!out_valid_q || out_ready_i)) |=> (finish || !out_valid_q || out_ready_i))
    else $error("result not produced in its execute cycle");

endmodule

`default_nettype wire

FILE: tb/id_pool_free_list_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_pool_free_list_allocator_tb
// Self-checking bench: a table of directed requests, then random request
// streams, all scored against a behavioral model of the free list, the bump
// counter and the size store.
// ----------------------------------------------------------------------------

module id_pool_free_list_allocator_tb;
  import ipfl_pkg::*;

  // capacity above the id range, so the usable pool is clamped to the id space
  localparam int unsigned PoolCap    = IdSpace + 8;
  localparam int unsigned UsableIds  = (PoolCap > IdSpace) ? IdSpace : PoolCap;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned PlanLen    = 24;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [SizeW-1:0]   size;
    logic [StatusW-1:0] status;
  } result_t;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [IdW-1:0]     id;
    logic [SizeW-1:0]   size;
    logic               typed;
    logic [IdW-1:0]     exp_id;
    logic [SizeW-1:0]   exp_size;
    logic [StatusW-1:0] exp_status;
  } plan_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               req_valid  = 1'b0;
  logic [OpW-1:0]     req_op     = OpAlloc;
  logic [IdW-1:0]     req_id     = '0;
  logic [SizeW-1:0]   req_size   = '0;
  logic               rsp_ready  = 1'b0;
  wire                req_ready;
  wire                rsp_valid;
  wire [IdW-1:0]      rsp_id;
  wire [SizeW-1:0]    rsp_size;
  wire [StatusW-1:0]  rsp_status;

  id_pool_free_list_allocator #(
    .CAPACITY(PoolCap)
  ) uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_ready_o   (req_ready),
    .opcode_i     (req_op),
    .entry_id_i   (req_id),
    .scope_size_i (req_size),
    .out_valid_o  (rsp_valid),
    .out_ready_i  (rsp_ready),
    .result_id_o  (rsp_id),
    .result_size_o(rsp_size),
    .status_o     (rsp_status)
  );

  // model of the pool state
  logic [IdW-1:0]    link_mem [IdSpace];
  logic [SizeW-1:0]  size_mem [IdSpace];
  logic [IdW-1:0]    pool_head     = '0;
  logic              pool_nonempty = 1'b0;
  logic [CountW-1:0] pool_bump     = '0;

  // id bookkeeping that keeps random frees from looping the list
  bit             listed  [IdSpace];
  bit             live    [IdSpace];
  bit             written [IdSpace];
  logic [IdW-1:0] live_q[$];
  logic [IdW-1:0] written_q[$];

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_count = 0;
  int unsigned items_sent = 0;
  int unsigned tx_mode    = 0;
  int unsigned rx_mode    = 0;
  int unsigned rx_window  = 0;
  int unsigned rx_hold    = 0;
  bit          quiet      = 1'b0;

  // directed requests; typed rows carry their result, the rest go to the model
  plan_row_t plan [PlanLen] = '{
    '{OpAlloc,  12'h000, 16'h0000, 1'b1, 12'h000, 16'h0000, StOk},
    '{OpAlloc,  12'hFFF, 16'hFFFF, 1'b1, 12'h001, 16'hFFFF, StOk},
    '{OpAlloc,  12'h555, 16'h1234, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'h001, 16'h0000, 1'b1, 12'h001, 16'hFFFF, StOk},
    '{OpLookup, 12'h000, 16'hFFFF, 1'b1, 12'h000, 16'h0000, StOk},
    '{OpBad,    12'hFFF, 16'hFFFF, 1'b1, 12'hFFF, 16'h0000, StBadOp},
    '{OpBad,    12'h000, 16'h0000, 1'b1, 12'h000, 16'h0000, StBadOp},
    '{OpFree,   12'h001, 16'h0000, 1'b1, 12'h001, 16'h0000, StOk},
    // free of an id never handed out
    '{OpFree,   12'hFFF, 16'hFFFF, 1'b1, 12'hFFF, 16'h0000, StOk},
    // same head freed again truncates the list to that id
    '{OpFree,   12'hFFF, 16'h0000, 1'b1, 12'hFFF, 16'h0000, StOk},
    '{OpAlloc,  12'h000, 16'hAAAA, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpAlloc,  12'hFFF, 16'h5555, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'hFFF, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpFree,   12'h002, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpFree,   12'h800, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpFree,   12'h7FF, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpAlloc,  12'h000, 16'h8000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpAlloc,  12'h000, 16'h0001, 1'b0, 12'h000, 16'h0000, StOk},
    // pop of the self-linked tail empties the list
    '{OpAlloc,  12'h000, 16'h7FFF, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpAlloc,  12'hFFF, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'h800, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'h002, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'h7FF, 16'h0000, 1'b0, 12'h000, 16'h0000, StOk},
    '{OpLookup, 12'h003, 16'hFFFF, 1'b0, 12'h000, 16'h0000, StOk}
  };

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // predict one request and advance the pool state
  task automatic pool_predict(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                              input logic [SizeW-1:0] size, output result_t res);
    logic [IdW-1:0] got;
    logic [IdW-1:0] nxt;
    bit             granted;
    res.id     = id;
    res.size   = '0;
    res.status = StOk;
    granted    = 1'b1;
    got        = '0;
    case (op)
      OpAlloc: begin
        if (pool_nonempty) begin
          got = pool_head;
          nxt = link_mem[got];
          if (nxt == got) pool_nonempty = 1'b0;
          else pool_head = nxt;
        end else if (pool_bump < UsableIds) begin
          got       = pool_bump[IdW-1:0];
          pool_bump = pool_bump + 1'b1;
        end else begin
          granted = 1'b0;
        end
        if (granted) begin
          size_mem[got] = size;
          res.id        = got;
          res.size      = size;
        end else begin
          res.id     = '0;
          res.status = StEmpty;
        end
      end
      OpFree: begin
        link_mem[id]  = pool_nonempty ? pool_head : id;
        pool_head     = id;
        pool_nonempty = 1'b1;
      end
      OpLookup: res.size = size_mem[id];
      default:  res.status = StBadOp;
    endcase
  endtask

  // drive one request, hold it until accepted, then record its expected result
  task automatic issue_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                               input logic [SizeW-1:0] size, input bit typed,
                               input result_t typed_res);
    int unsigned gap;
    bit          head_again;
    result_t     res;
    if (items_sent % 40 == 0) tx_mode = $urandom_range(0, 2);
    items_sent++;
    gap = 0;
    if (!quiet && tx_mode != 0 && $urandom_range(0, (tx_mode == 1) ? 7 : 1) == 0)
      gap = $urandom_range(1, 8);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_id    <= id;
    req_size  <= size;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    head_again = pool_nonempty && id == pool_head;
    pool_predict(op, id, size, res);
    pending_results.push_back(typed ? typed_res : res);
    // track which ids sit on the list, are handed out, or hold a size
    if (op == OpFree) begin
      if (head_again) begin
        foreach (listed[i]) listed[i] = 1'b0;
      end
      listed[id] = 1'b1;
      live[id]   = 1'b0;
    end else if (op == OpAlloc && res.status == StOk) begin
      listed[res.id] = 1'b0;
      live[res.id]   = 1'b1;
      live_q.push_back(res.id);
      if (!written[res.id]) begin
        written[res.id] = 1'b1;
        written_q.push_back(res.id);
      end
    end
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return SizeW'($urandom);
  endfunction

  // one random request: mostly allocate / free / lookup on sane ids, some noise
  task automatic random_request();
    int unsigned    roll;
    int unsigned    pick;
    int unsigned    idx;
    int unsigned    tries;
    logic [IdW-1:0] cand;
    bit             found;
    roll = $urandom_range(0, 99);
    if (roll < 40 || (roll >= 65 && roll < 92 && written_q.size() == 0)) begin
      issue_request(OpAlloc, IdW'($urandom), pick_size(), 1'b0, '0);
    end else if (roll < 65) begin
      found = 1'b0;
      cand  = '0;
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
        while (!found && live_q.size() != 0) begin
          idx   = $urandom_range(0, live_q.size() - 1);
          cand  = live_q[idx];
          live_q.delete(idx);
          found = live[cand];
        end
      end else if (pick < 75 && pool_nonempty) begin
        cand  = pool_head;
        found = 1'b1;
      end
      // any id off the list, or the head itself, keeps the list acyclic
      tries = 0;
      while (!found && tries < 16) begin
        cand  = IdW'($urandom);
        found = !listed[cand] || (pool_nonempty && cand == pool_head);
        tries++;
      end
      if (!found) cand = pool_head;
      issue_request(OpFree, cand, SizeW'($urandom), 1'b0, '0);
    end else if (roll < 92) begin
      cand = written_q[$urandom_range(0, written_q.size() - 1)];
      issue_request(OpLookup, cand, SizeW'($urandom), 1'b0, '0);
    end else begin
      issue_request(OpBad, IdW'($urandom), SizeW'($urandom), 1'b0, '0);
    end
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side backpressure in bursts, the mode redrawn whenever its window runs out
  always @(posedge clk) begin
    if (rx_window == 0) begin
      rx_mode   <= $urandom_range(0, 2);
      rx_window <= 63;
    end else begin
      rx_window <= rx_window - 1;
    end
    if (quiet) begin
      rsp_ready <= 1'b1;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rsp_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 7 : 2) == 0) begin
      rsp_ready <= 1'b0;
      rx_hold   <= $urandom_range(0, 7);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // score each accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && rsp_valid && rsp_ready) begin
      got = {rsp_id, rsp_size, rsp_status};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: id=%h size=%h status=%0d", got.id, got.size,
                   got.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.id !== want.id || got.size !== want.size || got.status !== want.status) begin
          if (mismatches < 10)
            $display("mismatch: expected id=%h size=%h status=%0d, got id=%h size=%h status=%0d",
                     want.id, want.size, want.status, got.id, got.size, got.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned k;
    result_t     typed_res;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (k = 0; k < PlanLen; k++) begin
      typed_res = {plan[k].exp_id, plan[k].exp_size, plan[k].exp_status};
      issue_request(plan[k].op, plan[k].id, plan[k].size, plan[k].typed, typed_res);
    end

    // random mix on a partly used pool
    repeat (300) random_request();

    // hold off until the block has answered everything
    wait_for_results();

    // more random mix, last stretch without idling
    repeat (250) random_request();
    quiet = 1'b1;
    repeat (100) random_request();

    wait_for_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
design/ipfl_pkg.sv
design/id_pool_free_list_allocator.sv
tb/id_pool_free_list_allocator_tb.sv
